@@ src/assert_macros.svh @@
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

@@ src/ils_pkg.sv @@
package ils_pkg;

  localparam int ILS_DEPTH     = 64;
  localparam int ILS_WORD_BITS = 32;

  localparam int REQ_BITS    = 3;
  localparam int POS_BITS    = 6;
  localparam int WORD_IO     = 32;
  localparam int FILL_BITS   = 7;
  localparam int STATUS_BITS = 2;

  localparam int IN_TDATA_BITS  = 40;  // position + word_in, byte padded
  localparam int OUT_TDATA_BITS = 40;  // word_out + fill_count, byte padded

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_READ   = 3'd4,
    REQ_WRITE  = 3'd5,
    REQ_CLEAR  = 3'd6
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_RD_WAIT  = 8'b0000_0100,
    S_RM_FIRST = 8'b0000_1000,
    S_MOVE_DN  = 8'b0001_0000,
    S_MOVE_UP  = 8'b0010_0000,
    S_INS_WR   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

endpackage

@@ src/indexed_list_store.sv @@
// indexed_list_store: bounded ordered list of signed words with a fill count.
// Input channel in_*: one request per transfer. in_tuser carries the request
// code (push, pop last, remove at index, insert at index, read, write, clear);
// in_tdata carries the position and the data word.
// Result channel out_*: exactly one transfer per request, with the word that
// was popped, removed or read (zero otherwise), the count after the request
// and a status (ok, empty, index out of range, full). Flagged requests change
// nothing.
// Sequence: push, write, clear, insert at the count and flagged requests pass
// through EXEC and DONE; pop and read add RD_WAIT for the RAM read. Remove
// reads the entry in RM_FIRST, then shifts the entries above it down in
// MOVE_DN; a shifting insert moves entries up in MOVE_UP, then writes the word
// in INS_WR. Entries move one per cycle through the single write port of the
// entry RAM. in_tready is high only while the sequencer is idle, one request
// at a time; it returns in the same cycle as out_tvalid rises.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls, the sequencer holds its finished
// result until the output register frees up.
// Reset: the fill count clears to zero, no pass over the RAM is needed since
// only entries below the count are ever read.
`include "assert_macros.svh"

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int DEPTH     = ILS_DEPTH,
  parameter int WORD_BITS = ILS_WORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [5:0] position, [37:6] word_in, rest 0
  input  logic [REQ_BITS-1:0]       in_tuser,   // [2:0] req_type
  // result channel
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [31:0] word_out, [38:32] fill_count, rest 0
  output logic [STATUS_BITS-1:0]    out_tuser   // [1:0] status
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS + 1;

  state_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  req_t                       req_r;
  logic [POS_BITS-1:0]        pos_r;
  logic signed [WORD_BITS-1:0] word_r;
  status_t                    status_r, status_nxt;
  logic signed [WORD_IO-1:0]  res_r, res_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [WORD_IO-1:0]         out_word_r;
  logic [FILL_BITS-1:0]       out_fill_r;
  status_t                    out_status_r;
  logic                       out_load;

  // RAM ports
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [WORD_BITS-1:0]       ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic signed [WORD_BITS-1:0] ram_rdata;

  // widened views for range checks
  logic [CMPW-1:0] pos_ext, cnt_ext, idx_ext;
  logic            in_xfer;
  logic            full;

  assign in_xfer = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count_r);
  assign idx_ext = CMPW'(idx_r);
  assign full    = (count_r == CW'(DEPTH));

  ils_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // request latch, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r  <= req_t'(in_tuser);
      pos_r  <= in_tdata[POS_BITS-1:0];
      // sign-extend or cut the 32-bit word to the stored width
      word_r <= WORD_BITS'($signed(in_tdata[POS_BITS +: WORD_IO]));
    end
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(idx_r);
    ram_wdata  = ram_rdata;
    ram_raddr  = AW'(idx_r);
    out_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_OK;
        res_nxt    = '0;
        state_nxt  = S_DONE;
        unique case (req_r)
          REQ_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_r);
              ram_wdata = word_r;
            end
          end
          REQ_POP: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              ram_raddr = AW'(count_r - CW'(1));
              state_nxt = S_RD_WAIT;
            end
          end
          REQ_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              ram_raddr = AW'(pos_r);
              idx_nxt   = CW'(pos_r);
              state_nxt = S_RM_FIRST;
            end
          end
          REQ_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              status_nxt = ST_RANGE;
            end else if (pos_ext == cnt_ext) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pos_r);
              ram_wdata = word_r;
            end else begin
              // move top entry first, work down toward the insert point
              ram_raddr = AW'(count_r - CW'(1));
              idx_nxt   = count_r;
              state_nxt = S_MOVE_UP;
            end
          end
          REQ_READ: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              ram_raddr = AW'(pos_r);
              state_nxt = S_RD_WAIT;
            end
          end
          REQ_WRITE: begin
            if (pos_ext >= cnt_ext) begin
              status_nxt = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pos_r);
              ram_wdata = word_r;
            end
          end
          REQ_CLEAR: begin
          end
          default: begin
          end
        endcase
      end

      S_RD_WAIT: begin
        res_nxt   = WORD_IO'(ram_rdata);
        state_nxt = S_DONE;
      end

      S_RM_FIRST: begin
        res_nxt = WORD_IO'(ram_rdata);
        if (idx_r + CW'(1) < count_r) begin
          ram_raddr = AW'(idx_r + CW'(1));
          state_nxt = S_MOVE_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_MOVE_DN: begin
        // entry idx+1 arrives from the RAM, lands at idx
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + CW'(1);
        if (idx_r + CW'(2) < count_r) begin
          ram_raddr = AW'(idx_r + CW'(2));
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_MOVE_UP: begin
        // entry idx-1 arrives from the RAM, lands at idx
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = ram_rdata;
        if (idx_ext - CMPW'(1) > pos_ext) begin
          ram_raddr = AW'(idx_r - CW'(2));
          idx_nxt   = idx_r - CW'(1);
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos_r);
        ram_wdata = word_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // count update when the result is committed
  always_comb begin
    count_nxt = count_r;
    if (out_load && status_r == ST_OK) begin
      unique case (req_r)
        REQ_PUSH, REQ_INSERT: count_nxt = count_r + CW'(1);
        REQ_POP, REQ_REMOVE:  count_nxt = count_r - CW'(1);
        REQ_CLEAR:            count_nxt = '0;
        default:              count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_word_r   <= res_r;
      out_fill_r   <= FILL_BITS'(count_nxt);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_BITS - WORD_IO - FILL_BITS){1'b0}}, out_fill_r, out_word_r};
  assign out_tuser  = out_status_r;

  // the fill count never passes the capacity
  `ASSERT_RST(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "fill count above capacity")
  // an accepted request always starts the sequencer
  `ASSERT_RST(a_accept_exec, clk, rst_n, in_xfer |=> (state_r == S_EXEC), "request not started")
  // downward moves stay inside the list
  `ASSERT_RST(a_move_dn, clk, rst_n,
              (state_r == S_MOVE_DN) |-> (idx_r + CW'(1) < count_r), "remove shift past end")
  // upward moves stay above the insert point and within the list
  `ASSERT_RST(a_move_up, clk, rst_n,
              (state_r == S_MOVE_UP) |-> ((idx_ext > pos_ext) && (idx_r <= count_r)),
              "insert shift out of range")

endmodule

@@ src/ils_ram.sv @@
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
